FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define SPF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// The expression must never be true outside of reset.
`define SPF_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

FILE: hw/rtl/spf_pkg.sv
// Shared types and constants for the shortest-path frontier block.
// No dependencies.
package spf_pkg;

    localparam int NODES_DEFAULT = 64;
    localparam int OP_W          = 2;
    localparam int NODE_W        = 6;
    localparam int WEIGHT_W      = 16;
    localparam int DIST_W        = 31;
    localparam int CFG_W         = 7;
    localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 7'd64;
    localparam logic [DIST_W-1:0] DIST_INF = 31'h7FFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_RELAX = 2'd1,
        OP_POP   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS0,
        ST_PASS1,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] pred;
        logic              pred_valid;
        logic              queued;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{distance: DIST_INF, pred: '0, pred_valid: 1'b0,
                                       queued: 1'b0};

    // what the controller feeds into the first cell of the ring
    typedef struct packed {
        logic   shift;
        entry_t data;
    } chain_ctl_t;

endpackage

FILE: hw/rtl/spf_cell.sv
// One cell of the node ring: holds one node entry and hands it on when shifting.
// Depends on spf_pkg.
module spf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  spf_pkg::entry_t entry_in,
    output spf_pkg::entry_t entry_out
);
    import spf_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = shift ? entry_in : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_RESET;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out = entry_reg;

endmodule

FILE: hw/rtl/spf_ctrl.sv
// Sequencer and head-of-ring logic: runs one or two passes of the node ring per
// command, rewrites entries as they pass the head, and forms the result word.
// Depends on spf_pkg.
module spf_ctrl #(
    parameter int NODES = spf_pkg::NODES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spf_pkg::OP_W-1:0]     operation,
    input  logic [spf_pkg::NODE_W-1:0]   node,
    input  logic [spf_pkg::NODE_W-1:0]   target,
    input  logic [spf_pkg::WEIGHT_W-1:0] weight,
    input  logic                        node_count_we,
    input  logic [spf_pkg::CFG_W-1:0]    node_count,
    input  spf_pkg::entry_t             head,
    output spf_pkg::chain_ctl_t         chain,
    output logic                        busy,
    output logic                        done,
    output logic [spf_pkg::NODE_W-1:0]   out_node,
    output logic [spf_pkg::DIST_W-1:0]   out_dist,
    output logic [spf_pkg::NODE_W-1:0]   out_pred,
    output logic                        has_pred,
    output logic                        flag
);
    import spf_pkg::*;

    localparam int IW = $clog2(NODES);
    // wide enough for node indexes, the register and NODES itself
    localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
    localparam logic [IW-1:0] POS_LAST = IW'(NODES - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(NODES);

    state_t              state_reg, state_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [CFG_W-1:0]    node_count_reg, node_count_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic                upd_reg, upd_next;

    op_t                 op_reg, op_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [NODE_W-1:0]   target_reg, target_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DIST_W-1:0]   da_reg, da_next;
    entry_t              cap_reg, cap_next;
    logic [IW-1:0]       best_reg, best_next;
    logic [NODE_W-1:0]   out_node_reg, out_node_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [NODE_W-1:0]   out_pred_reg, out_pred_next;
    logic                has_pred_reg, has_pred_next;
    logic                flag_reg, flag_next;

    logic [CW-1:0]       idx_x, a_x, b_x, cfg_x, eff_cnt;
    logic                a_hit, b_hit, a_in, b_in, pos_last, relax_ok;
    logic [DIST_W:0]     sum;
    entry_t              upd_e;

    assign idx_x    = CW'(pos_reg);
    assign a_x      = CW'(node_reg);
    assign b_x      = CW'(target_reg);
    assign cfg_x    = CW'(node_count_reg);
    assign eff_cnt  = (cfg_x < CNT_MAX) ? cfg_x : CNT_MAX;
    assign a_hit    = (idx_x == a_x);
    assign b_hit    = (idx_x == b_x);
    assign a_in     = (a_x < cnt_reg);
    assign b_in     = (b_x < cnt_reg);
    assign pos_last = (pos_reg == POS_LAST);
    assign sum      = {1'b0, da_reg} + (DIST_W + 1)'(weight_reg);
    assign relax_ok = a_in && b_in && (da_reg != DIST_INF)
                      && (sum < {1'b0, DIST_INF}) && (sum < {1'b0, head.distance});

    always_comb
    begin
        upd_e            = head;
        upd_e.distance   = sum[DIST_W-1:0];
        upd_e.pred       = node_reg;
        upd_e.pred_valid = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        node_count_next = node_count_we ? node_count : node_count_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        upd_next        = upd_reg;
        op_next         = op_reg;
        node_next       = node_reg;
        target_next     = target_reg;
        weight_next     = weight_reg;
        cnt_next        = cnt_reg;
        da_next         = da_reg;
        cap_next        = cap_reg;
        best_next       = best_reg;
        out_node_next   = out_node_reg;
        out_dist_next   = out_dist_reg;
        out_pred_next   = out_pred_reg;
        has_pred_next   = has_pred_reg;
        flag_next       = flag_reg;
        chain.shift     = 1'b0;
        chain.data      = head;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_t'(operation);
                    node_next   = node;
                    target_next = target;
                    weight_next = weight;
                    cnt_next    = eff_cnt;
                    pos_next    = '0;
                    da_next     = DIST_INF;
                    cap_next    = ENTRY_RESET;
                    found_next  = 1'b0;
                    best_next   = '0;
                    upd_next    = 1'b0;
                    state_next  = ST_PASS0;
                end
            end
            ST_PASS0:
            begin
                chain.shift = 1'b1;
                pos_next    = pos_last ? '0 : pos_reg + 1'b1;
                case (op_reg)
                    OP_INIT:
                    begin
                        chain.data.distance   = (a_hit && a_in) ? '0 : DIST_INF;
                        chain.data.pred       = '0;
                        chain.data.pred_valid = 1'b0;
                        chain.data.queued     = (idx_x < cnt_reg);
                    end
                    OP_RELAX:
                    begin
                        if (a_hit)
                        begin
                            da_next = head.distance;
                        end
                    end
                    OP_POP:
                    begin
                        // strict compare keeps the lowest index on ties
                        if (head.queued && (!found_reg || head.distance < cap_reg.distance))
                        begin
                            found_next = 1'b1;
                            best_next  = pos_reg;
                            cap_next   = head;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (a_hit)
                        begin
                            cap_next = head;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (pos_last)
                begin
                    state_next = (op_reg == OP_RELAX || op_reg == OP_POP) ? ST_PASS1
                                                                           : ST_RESULT;
                end
            end
            ST_PASS1:
            begin
                chain.shift = 1'b1;
                pos_next    = pos_last ? '0 : pos_reg + 1'b1;
                if (op_reg == OP_RELAX)
                begin
                    if (b_hit)
                    begin
                        if (relax_ok)
                        begin
                            chain.data = upd_e;
                            cap_next   = upd_e;
                            upd_next   = 1'b1;
                        end
                        else
                        begin
                            cap_next = head;
                        end
                    end
                end
                else if (found_reg && pos_reg == best_reg)
                begin
                    chain.data.queued = 1'b0;
                end
                if (pos_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                out_dist_next = cap_reg.distance;
                out_pred_next = cap_reg.pred_valid ? cap_reg.pred : '0;
                has_pred_next = cap_reg.pred_valid;
                case (op_reg)
                    OP_INIT:
                    begin
                        out_node_next = node_reg;
                        out_dist_next = a_in ? '0 : DIST_INF;
                        out_pred_next = '0;
                        has_pred_next = 1'b0;
                        flag_next     = 1'b0;
                    end
                    OP_RELAX:
                    begin
                        out_node_next = target_reg;
                        flag_next     = upd_reg;
                    end
                    OP_POP:
                    begin
                        out_node_next = found_reg ? NODE_W'(best_reg) : '0;
                        flag_next     = found_reg;
                    end
                    OP_QUERY:
                    begin
                        out_node_next = node_reg;
                        flag_next     = cap_reg.queued;
                    end
                    default:
                    begin
                    end
                endcase
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            upd_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            node_count_reg <= node_count_next;
            done_reg       <= done_next;
            found_reg      <= found_next;
            upd_reg        <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        node_reg     <= node_next;
        target_reg   <= target_next;
        weight_reg   <= weight_next;
        cnt_reg      <= cnt_next;
        da_reg       <= da_next;
        cap_reg      <= cap_next;
        best_reg     <= best_next;
        out_node_reg <= out_node_next;
        out_dist_reg <= out_dist_next;
        out_pred_reg <= out_pred_next;
        has_pred_reg <= has_pred_next;
        flag_reg     <= flag_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign out_node = out_node_reg;
    assign out_dist = out_dist_reg;
    assign out_pred = out_pred_reg;
    assign has_pred = has_pred_reg;
    assign flag     = flag_reg;

endmodule

FILE: hw/rtl/shortest_path_frontier.sv
// Top level of the shortest-path frontier: a ring of NODES entry cells and the
// sequencer that works at the ring's head. Depends on spf_pkg, spf_cell, spf_ctrl.
//
// Usage:
//   Command channel: a word (operation, node, target, weight) is taken at a
//   rising edge with start high and busy low. busy stays high until the result.
//   Result channel: done pulses for one cycle with out_node, out_dist,
//   out_pred, has_pred and flag valid in that cycle. There is no back-pressure.
//   Config: node_count is written on any edge with node_count_we high; write
//   it only while busy is low and no result is pending.
//   Timing: the node entries circulate through the ring, one entry past the
//   head per cycle. Init and query take one revolution, relax and pop take two
//   (the first finds the origin distance or the minimum, the second applies the
//   update). done is registered from the result state that follows the last
//   revolution; a new command may be given in the cycle done is high.
//   Reset: all entries infinite, unqueued, no predecessor; node_count = 64.
module shortest_path_frontier #(
    parameter int NODES = spf_pkg::NODES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spf_pkg::OP_W-1:0]     operation,
    input  logic [spf_pkg::NODE_W-1:0]   node,
    input  logic [spf_pkg::NODE_W-1:0]   target,
    input  logic [spf_pkg::WEIGHT_W-1:0] weight,
    input  logic                        node_count_we,
    input  logic [spf_pkg::CFG_W-1:0]    node_count,
    output logic                        busy,
    output logic                        done,
    output logic [spf_pkg::NODE_W-1:0]   out_node,
    output logic [spf_pkg::DIST_W-1:0]   out_dist,
    output logic [spf_pkg::NODE_W-1:0]   out_pred,
    output logic                        has_pred,
    output logic                        flag
);
    import spf_pkg::*;

    chain_ctl_t chain;
    entry_t     ring [NODES];

    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                spf_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (chain.shift),
                    .entry_in  (chain.data),
                    .entry_out (ring[gi])
                );
            end
            else
            begin : g_rest
                spf_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (chain.shift),
                    .entry_in  (ring[gi-1]),
                    .entry_out (ring[gi])
                );
            end
        end
    endgenerate

    spf_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operation     (operation),
        .node          (node),
        .target        (target),
        .weight        (weight),
        .node_count_we (node_count_we),
        .node_count    (node_count),
        .head          (ring[NODES-1]),
        .chain         (chain),
        .busy          (busy),
        .done          (done),
        .out_node      (out_node),
        .out_dist      (out_dist),
        .out_pred      (out_pred),
        .has_pred      (has_pred),
        .flag          (flag)
    );

endmodule

FILE: hw/rtl/spf_checker.sv
// Port-level checks for shortest_path_frontier, attached by bind.
// Depends on spf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [spf_pkg::NODE_W-1:0]   out_pred,
    input logic                        has_pred
);
    import spf_pkg::*;

    // an accepted command word always makes the block busy
    `SPF_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    // a result word comes only when the block has finished
    `SPF_NEVER(a_done_while_busy, clk, rst_n, done && busy)
    // every command ends in exactly one result word
    `SPF_ASSERT(a_fall_done, clk, rst_n, $fell(busy) |-> done)
    `SPF_ASSERT(a_done_pulse, clk, rst_n, done |=> !done)
    // no recorded predecessor reads as zero
    `SPF_NEVER(a_pred_zero, clk, rst_n, done && !has_pred && (out_pred != '0))

endmodule

bind shortest_path_frontier spf_checker u_spf_checker (.*);
